[hdl/bgc_pkg.sv]
`timescale 1ns / 1ps

package bgc_pkg;

  // Default converter width
  localparam int READING_BITS_DEF = 12;

  // Scaling constants
  localparam int PIN_SCALE_MV  = 3300;
  localparam int PERCENT_FULL  = 100;
  localparam int MV_W          = 15;
  localparam int PCT_W         = 7;
  localparam int CNT_W         = 4;
  localparam int RATIO_W       = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 15;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_RATIO      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MILLIVOLTS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MILLIVOLTS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_MILLIVOLTS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE_LIMIT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READING_CALIBRATED = 3'd5;

  // Register reset values
  localparam logic [RATIO_W-1:0] RST_DIVIDER_RATIO     = 4'd3;
  localparam logic [MV_W-1:0]    RST_EMPTY_MILLIVOLTS  = 15'd3300;
  localparam logic [MV_W-1:0]    RST_FULL_MILLIVOLTS   = 15'd4200;
  localparam logic [MV_W-1:0]    RST_CUTOFF_MILLIVOLTS = 15'd3250;
  localparam logic [CNT_W-1:0]   RST_STRIKE_LIMIT      = 4'd3;

  // No percentage seen yet
  localparam logic [7:0] PCT_NONE = 8'hFF;

endpackage

[hdl/battery_gauge_cutoff_top.sv]
`timescale 1ns / 1ps

// Channel | Ports                          | Beat contents (low bit up)
// --------+--------------------------------+---------------------------------------------
// input   | in_tvalid, in_tready, in_tdata | reading, zero fill to whole bytes
// result  | out_tvalid,out_tready,out_tdata| battery_millivolts[14:0], charge_percent[21:15],
//         |                                | low_count[25:22], power_off[26], zero[31:27]
// config  | cfg_valid, cfg_ready,          | cfg_index selects the register, cfg_data is
//         | cfg_index, cfg_data            | the value (low bits used); cfg_ready is always 1
//
// A raw code is scaled to pin millivolts by the first divide; a calibrated reading
// skips it. The result appears in the same cycle as in_tready rises again. Skip the
// second divide when the percentage is zero outright (full not above empty, or
// battery at or below empty). After power off a beat skips both divides and reports
// the held state. The restoring divider retires one quotient bit per cycle and is
// shared by the code scaling and the gauge percentage.
// Reset (rst_n low, synchronous) restores register defaults and clears strikes.
// A finished result waits in the output register while the next beat is accepted;
// a result that cannot leave holds the block in its last state.

module battery_gauge_cutoff_top
  import bgc_pkg::*;
#(
  parameter int READING_BITS = READING_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // reading in [READING_BITS-1:0], zero fill above
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((READING_BITS + 7) / 8)*8-1:0] in_tdata,
  // battery_millivolts, charge_percent, low_count, power_off, zero fill
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [31:0]                          out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [CFG_DATA_W-1:0]                cfg_data
);

  // Dividend is wide enough for code*3300 and for (mv-empty)*100
  localparam int NUM_W  = (READING_BITS + 12 > 22) ? READING_BITS + 12 : 22;
  // Divisor holds the full-scale code or the gauge span
  localparam int DEN_W  = (READING_BITS > MV_W) ? READING_BITS : MV_W;
  // Pin millivolts: calibrated reading or scaled code (at most 3300)
  localparam int PIN_W  = (READING_BITS > 12) ? READING_BITS : 12;
  localparam int BAT_W  = PIN_W + RATIO_W;
  localparam int ITER_W = $clog2(NUM_W);
  localparam logic [DEN_W-1:0] FULL_CODE =
    DEN_W'((64'd1 << READING_BITS) - 64'd1);
  localparam int MV_MAX_C = (1 << MV_W) - 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_BAT,
    S_PCT,
    S_DIV2,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;

  // Configuration registers
  logic [RATIO_W-1:0]      ratio_r;
  logic [MV_W-1:0]         empty_r;
  logic [MV_W-1:0]         full_r;
  logic [MV_W-1:0]         cutoff_r;
  logic [CNT_W-1:0]        limit_r;
  logic                    calib_r;

  // Gauge state
  logic [CNT_W-1:0]        strike_r, strike_nxt;
  logic [7:0]              prev_r;
  logic                    cut_r, cut_nxt;
  logic                    skip_r, skip_nxt;   // item arrived after power off

  // Datapath
  logic [NUM_W-1:0]        acc_r, acc_nxt;     // dividend, quotient shifts in below
  logic [DEN_W-1:0]        rem_r, rem_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic [ITER_W-1:0]       iter_r, iter_nxt;
  logic [MV_W-1:0]         bat_r, bat_nxt;
  logic [PCT_W-1:0]        pct_r, pct_nxt;

  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [31:0]             out_tdata_r, out_tdata_nxt;

  logic [READING_BITS-1:0] reading;
  logic [DEN_W:0]          trial;
  logic                    fits;
  logic [NUM_W-1:0]        quot;
  logic [BAT_W-1:0]        bat_full;
  logic [MV_W-1:0]         diff;
  logic                    keep_count;
  logic                    is_low;
  logic [CNT_W-1:0]        strike_inc;
  logic                    out_free;

  assign reading    = in_tdata[READING_BITS-1:0];
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // Shared divider: one restoring step per cycle
  assign trial = {rem_r, acc_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});
  assign quot  = {acc_r[NUM_W-2:0], fits};

  assign bat_full = BAT_W'(acc_r[PIN_W-1:0]) * BAT_W'(ratio_r);
  assign diff     = bat_r - empty_r;

  // Strike bookkeeping for the finished item
  assign keep_count = (bat_r == '0) && ({1'b0, pct_r} == prev_r);
  assign is_low     = (bat_r != '0) && (bat_r < cutoff_r);
  assign strike_inc = (strike_r == {CNT_W{1'b1}}) ? strike_r : strike_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    den_nxt        = den_r;
    iter_nxt       = iter_r;
    bat_nxt        = bat_r;
    pct_nxt        = pct_r;
    skip_nxt       = skip_r;
    strike_nxt     = strike_r;
    cut_nxt        = cut_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          skip_nxt = cut_r;
          rem_nxt  = '0;
          den_nxt  = FULL_CODE;
          iter_nxt = ITER_W'(NUM_W - 1);
          if (cut_r) begin
            // Ignore the reading, report the held state
            bat_nxt   = '0;
            pct_nxt   = prev_r[PCT_W-1:0];
            state_nxt = S_DONE;
          end else if (calib_r) begin
            acc_nxt   = NUM_W'(reading);
            state_nxt = S_BAT;
          end else begin
            acc_nxt   = NUM_W'(reading) * NUM_W'(PIN_SCALE_MV);
            state_nxt = S_DIV1;
          end
        end
      end

      S_DIV1: begin
        acc_nxt  = quot;
        rem_nxt  = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        iter_nxt = iter_r - 1'b1;
        if (iter_r == '0) begin
          state_nxt = S_BAT;
        end
      end

      S_BAT: begin
        // Scale to battery side and saturate
        bat_nxt   = (bat_full > BAT_W'(MV_MAX_C)) ? MV_W'(MV_MAX_C) : bat_full[MV_W-1:0];
        state_nxt = S_PCT;
      end

      S_PCT: begin
        if ((full_r <= empty_r) || (bat_r <= empty_r)) begin
          pct_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          acc_nxt   = NUM_W'(diff) * NUM_W'(PERCENT_FULL);
          den_nxt   = DEN_W'(full_r - empty_r);
          rem_nxt   = '0;
          iter_nxt  = ITER_W'(NUM_W - 1);
          state_nxt = S_DIV2;
        end
      end

      S_DIV2: begin
        acc_nxt  = quot;
        rem_nxt  = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        iter_nxt = iter_r - 1'b1;
        if (iter_r == '0) begin
          pct_nxt   = (quot > NUM_W'(PERCENT_FULL)) ? PCT_W'(PERCENT_FULL)
                                                    : quot[PCT_W-1:0];
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the output register can take the beat
        if (out_free) begin
          if (!skip_r && !keep_count) begin
            if (is_low) begin
              strike_nxt = strike_inc;
              if (strike_inc >= limit_r) begin
                cut_nxt = 1'b1;
              end
            end else begin
              strike_nxt = '0;
            end
          end
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {5'd0, cut_nxt, strike_nxt, pct_r, bat_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      strike_r     <= '0;
      prev_r       <= PCT_NONE;
      cut_r        <= 1'b0;
      skip_r       <= 1'b0;
      ratio_r      <= RST_DIVIDER_RATIO;
      empty_r      <= RST_EMPTY_MILLIVOLTS;
      full_r       <= RST_FULL_MILLIVOLTS;
      cutoff_r     <= RST_CUTOFF_MILLIVOLTS;
      limit_r      <= RST_STRIKE_LIMIT;
      calib_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      out_tdata_r  <= out_tdata_nxt;
      strike_r     <= strike_nxt;
      cut_r        <= cut_nxt;
      skip_r       <= skip_nxt;
      acc_r        <= acc_nxt;
      rem_r        <= rem_nxt;
      den_r        <= den_nxt;
      iter_r       <= iter_nxt;
      bat_r        <= bat_nxt;
      pct_r        <= pct_nxt;
      // Record the percentage of every live item once it completes
      if (state_r == S_DONE && out_free && !skip_r) begin
        prev_r <= {1'b0, pct_r};
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_DIVIDER_RATIO:      ratio_r  <= cfg_data[RATIO_W-1:0];
          REG_EMPTY_MILLIVOLTS:   empty_r  <= cfg_data[MV_W-1:0];
          REG_FULL_MILLIVOLTS:    full_r   <= cfg_data[MV_W-1:0];
          REG_CUTOFF_MILLIVOLTS:  cutoff_r <= cfg_data[MV_W-1:0];
          REG_STRIKE_LIMIT:       limit_r  <= cfg_data[CNT_W-1:0];
          REG_READING_CALIBRATED: calib_r  <= cfg_data[0];
          default: begin
            // drop writes to unused indexes
          end
        endcase
      end
    end
  end

endmodule
